// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/wsma_pkg.sv =====
`default_nettype none

package wsma_pkg;

  // Field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned ROW_FW   = 4;
  localparam int unsigned COL_FW   = 4;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned PSUM_W   = 40;
  localparam int unsigned MAX_EMIT = 16;

  // Stream word widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 48;

  // Input word kinds
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_W  = 2'd0,
    ACT_STAGE   = 2'd1,
    ACT_STEP    = 2'd2,
    ACT_CLEAR_W = 2'd3
  } wsma_action_e;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic w_clr;       // zero all weights
    logic act_shift;   // take activations from left neighbor
    logic rotate;      // rotate row stores, multiply tap 0
    logic acc_clr;     // zero the column sum
    logic acc_en;      // add registered product
    logic psum_shift;  // take column sum from right neighbor
  } wsma_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/wsma_cell.sv =====
`default_nettype none

// One array column: its weights and activations for all rows, one multiplier
// and the column sum. Row stores rotate so that row i sits at tap 0 on MAC
// cycle i; after ROWS rotations they are back in place.
module wsma_cell #(
  parameter int unsigned ROWS = 16,
  localparam int unsigned RW  = $clog2(ROWS)
) (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire  wsma_pkg::wsma_ctrl_t                    ctrl_i,
  input  wire                                           w_we_i,
  input  wire  [RW-1:0]                                 wr_row_i,
  input  wire  [wsma_pkg::VAL_W-1:0]                    wr_val_i,
  input  wire  [ROWS-1:0][wsma_pkg::VAL_W-1:0]          act_i,
  output logic [ROWS-1:0][wsma_pkg::VAL_W-1:0]          act_o,
  input  wire  [wsma_pkg::PSUM_W-1:0]                   psum_i,
  output logic [wsma_pkg::PSUM_W-1:0]                   psum_o
);

  logic [ROWS-1:0][wsma_pkg::VAL_W-1:0] w_q;
  logic [ROWS-1:0][wsma_pkg::VAL_W-1:0] a_q;
  logic signed [wsma_pkg::VAL_W-1:0]    w_tap, a_tap;
  logic signed [wsma_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic [wsma_pkg::PSUM_W-1:0]          acc_q;

  // Weight store: clear, rotate or single-row write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (ctrl_i.w_clr) begin
      w_q <= '0;
    end else if (ctrl_i.rotate) begin
      w_q <= {w_q[0], w_q[ROWS-1:1]};
    end else if (w_we_i) begin
      w_q[wr_row_i] <= wr_val_i;
    end
  end

  // Activation store: column shift on step, rotate during MAC
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (ctrl_i.act_shift) begin
      a_q <= act_i;
    end else if (ctrl_i.rotate) begin
      a_q <= {a_q[0], a_q[ROWS-1:1]};
    end
  end

  assign act_o = a_q;

  // Product of the tap-0 pair, registered
  assign w_tap  = $signed(w_q[0]);
  assign a_tap  = $signed(a_q[0]);
  assign prod_d = w_tap * a_tap;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rotate) begin
      prod_q <= prod_d;
    end
  end

  // Column sum; shifts left during emit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + {{(wsma_pkg::PSUM_W-wsma_pkg::PROD_W){prod_q[wsma_pkg::PROD_W-1]}},
                        prod_q};
    end else if (ctrl_i.psum_shift) begin
      acc_q <= psum_i;
    end
  end

  assign psum_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/weight_stationary_mac_array_core.sv =====
// Weight-stationary multiply-accumulate array, ROWS x COLS cells.
// Input stream (s_axis_*): one word per command: load a Q8.8 weight into
// (row, col), stage a signed activation for a row, clear all weights, or step.
// Load, stage and clear produce no output; out-of-range rows or columns are
// ignored.
// A step shifts activations one column right, feeds the staged column into
// column 0, clears the staging buffer, then forms each column's exact sum of
// weight times activation over all rows.
// Output stream (m_axis_*): min(COLS,16) words per step, column 0 first,
// tlast on the final one. The sum walks the rows through one multiplier per
// column while the row stores rotate, then a drain state adds the last
// registered product before the first result is shown.
// s_axis_tready is low from the step until its last result is taken.
// A stalled sink holds the current result; the column sums wait in the chain.
// Reset (rst_ni low, asynchronous) zeroes all weights, activations and staged
// values at once; the block is ready as soon as reset is released.
`default_nettype none

module weight_stationary_mac_array_core #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // action[1:0], row[5:2], col[9:6], value[25:10], zero pad
  input  wire  [wsma_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // column[3:0], psum[43:4], zero pad
  output logic [wsma_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int unsigned RW   = $clog2(ROWS);
  localparam int unsigned CW   = $clog2(COLS);
  localparam int unsigned EMIT = (COLS < wsma_pkg::MAX_EMIT) ? COLS : wsma_pkg::MAX_EMIT;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [RW-1:0]                 row_cnt_q, row_cnt_d;
  logic [wsma_pkg::COL_FW-1:0]   emit_cnt_q, emit_cnt_d;
  logic                          prod_vld_q;

  wsma_pkg::wsma_action_e        in_action;
  logic [wsma_pkg::ROW_FW-1:0]   in_row;
  logic [wsma_pkg::COL_FW-1:0]   in_col;
  logic [wsma_pkg::VAL_W-1:0]    in_value;
  logic [31:0]                   row_ext, col_ext;
  logic [RW-1:0]                 row_idx;
  logic [CW-1:0]                 col_idx;
  logic                          row_ok, col_ok;
  logic                          s_hs, m_hs, step_acc, load_acc;

  wsma_pkg::wsma_ctrl_t          ctrl;
  logic [ROWS-1:0][wsma_pkg::VAL_W-1:0] staged_q;
  logic [ROWS-1:0][wsma_pkg::VAL_W-1:0] act_chain [COLS];
  logic [wsma_pkg::PSUM_W-1:0]          psum_chain [COLS];

  // Unpack the input word
  assign in_action = wsma_pkg::wsma_action_e'(s_axis_tdata[1:0]);
  assign in_row    = s_axis_tdata[5:2];
  assign in_col    = s_axis_tdata[9:6];
  assign in_value  = s_axis_tdata[25:10];

  assign row_ext = 32'(in_row);
  assign col_ext = 32'(in_col);
  assign row_idx = row_ext[RW-1:0];
  assign col_idx = col_ext[CW-1:0];
  assign row_ok  = (row_ext < ROWS);
  assign col_ok  = (col_ext < COLS);

  // Handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_hs          = m_axis_tvalid && m_axis_tready;
  assign step_acc      = s_hs && (in_action == wsma_pkg::ACT_STEP);
  assign load_acc      = s_hs && (in_action == wsma_pkg::ACT_LOAD_W) && row_ok && col_ok;

  // Chain control
  always_comb begin
    ctrl.w_clr      = s_hs && (in_action == wsma_pkg::ACT_CLEAR_W);
    ctrl.act_shift  = step_acc;
    ctrl.acc_clr    = step_acc;
    ctrl.rotate     = (state_q == ST_MAC);
    ctrl.acc_en     = prod_vld_q;
    ctrl.psum_shift = m_hs;
  end

  // Sequencer: rotate all rows, drain last product, emit columns
  always_comb begin
    state_d    = state_q;
    row_cnt_d  = row_cnt_q;
    emit_cnt_d = emit_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (step_acc) begin
          state_d   = ST_MAC;
          row_cnt_d = '0;
        end
      end
      ST_MAC: begin
        row_cnt_d = row_cnt_q + RW'(1);
        if (row_cnt_q == RW'(ROWS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d    = ST_EMIT;
        emit_cnt_d = '0;
      end
      ST_EMIT: begin
        if (m_hs) begin
          emit_cnt_d = emit_cnt_q + wsma_pkg::COL_FW'(1);
          if (m_axis_tlast) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_cnt_q  <= '0;
      emit_cnt_q <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_cnt_q  <= row_cnt_d;
      emit_cnt_q <= emit_cnt_d;
      prod_vld_q <= ctrl.rotate;
    end
  end

  // Staging buffer, cleared when a step takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q <= '0;
    end else if (step_acc) begin
      staged_q <= '0;
    end else if (s_hs && (in_action == wsma_pkg::ACT_STAGE) && row_ok) begin
      staged_q[row_idx] <= in_value;
    end
  end

  // Column cells
  for (genvar j = 0; j < COLS; j++) begin : g_col
    logic                                 we;
    logic [ROWS-1:0][wsma_pkg::VAL_W-1:0] act_in;
    logic [wsma_pkg::PSUM_W-1:0]          psum_in;

    assign we = load_acc && (col_idx == CW'(j));

    if (j == 0) begin : g_first
      assign act_in = staged_q;
    end else begin : g_inner
      assign act_in = act_chain[j-1];
    end

    if (j == COLS - 1) begin : g_last
      assign psum_in = '0;
    end else begin : g_mid
      assign psum_in = psum_chain[j+1];
    end

    wsma_cell #(
      .ROWS (ROWS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .w_we_i   (we),
      .wr_row_i (row_idx),
      .wr_val_i (in_value),
      .act_i    (act_in),
      .act_o    (act_chain[j]),
      .psum_i   (psum_in),
      .psum_o   (psum_chain[j])
    );
  end

  // Result word from the head of the chain
  assign m_axis_tdata = {{(wsma_pkg::M_TDATA_W - wsma_pkg::PSUM_W - wsma_pkg::COL_FW){1'b0}},
                         psum_chain[0], emit_cnt_q};
  assign m_axis_tlast = (emit_cnt_q == wsma_pkg::COL_FW'(EMIT - 1));

endmodule

`default_nettype wire

// ===== rtl/wsma_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module wsma_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire [wsma_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [wsma_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire                            m_axis_tlast
);

  logic s_hs, m_hs, step_hs;

  assign s_hs    = s_axis_tvalid && s_axis_tready;
  assign m_hs    = m_axis_tvalid && m_axis_tready;
  assign step_hs = s_hs && (s_axis_tdata[1:0] == wsma_pkg::ACT_STEP);

  // Stalled result holds
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // No input taken while results are pending
  `ASSERT_CLK(a_no_input_during_emit, m_axis_tvalid |-> !s_axis_tready, "input ready during emit")

  // A step closes the input and shows no result in the next cycle
  `ASSERT_CLK(a_step_busy, step_hs |=> !s_axis_tready && !m_axis_tvalid, "step did not start compute")

  // Columns count up by one within a step
  `ASSERT_CLK(a_col_incr, m_hs && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tdata[3:0] == 4'($past(m_axis_tdata[3:0]) + 4'd1)), "column sequence broken")

  // After the last column the block is ready again
  `ASSERT_CLK(a_last_release, m_hs && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready, "not idle after last")

endmodule

bind weight_stationary_mac_array_core wsma_checker u_wsma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsma_pkg::*;

  localparam int ROWS      = 16;
  localparam int COLS      = 16;
  localparam int EMIT      = (COLS < MAX_EMIT) ? COLS : MAX_EMIT;
  localparam int N_ITEMS   = 430;
  localparam int HOLD_LEN  = 300;
  localparam int TAIL      = ROWS + 2 + EMIT + 30;
  localparam int DOG_LIMIT = 5000;

  typedef struct {
    wsma_action_e       action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct {
    logic [3:0]         column;
    logic signed [39:0] psum;
    logic               last;
  } col_sum_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   s_valid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_data = '0;
  logic                   m_axis_tvalid;
  logic                   m_ready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;

  // commands waiting for the driver, column sums waiting for the monitor
  cmd_t     cmd_q[$];
  col_sum_t col_sums_q[$];
  cmd_t     cur_cmd;

  // shadow copy of the array state
  logic signed [15:0] weight_mem [ROWS][COLS];
  logic signed [15:0] act_mem    [ROWS][COLS];
  logic signed [15:0] staged_acts[ROWS];

  int errors       = 0;
  int cmds_taken   = 0;
  int steps_taken  = 0;
  int sums_seen    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int stall_cycles = 0;

  col_sum_t           want;
  logic [3:0]         got_col;
  logic signed [39:0] got_psum;

  weight_stationary_mac_array_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Apply one accepted command to the shadow state; a step queues its column sums.
  function automatic void update_array_model(cmd_t cmd);
    longint   acc;
    col_sum_t cs;
    case (cmd.action)
      ACT_LOAD_W: weight_mem[cmd.row][cmd.col] = cmd.value;
      ACT_STAGE:  staged_acts[cmd.row] = cmd.value;
      ACT_CLEAR_W: begin
        for (int r = 0; r < ROWS; r++)
          for (int k = 0; k < COLS; k++) weight_mem[r][k] = '0;
      end
      ACT_STEP: begin
        for (int r = 0; r < ROWS; r++) begin
          for (int k = COLS - 1; k > 0; k--) act_mem[r][k] = act_mem[r][k-1];
          act_mem[r][0] = staged_acts[r];
          staged_acts[r] = '0;
        end
        for (int k = 0; k < EMIT; k++) begin
          acc = 0;
          for (int r = 0; r < ROWS; r++)
            acc += longint'(weight_mem[r][k]) * longint'(act_mem[r][k]);
          cs.column = 4'(k);
          cs.psum   = acc[39:0];
          cs.last   = (k == EMIT - 1);
          col_sums_q.push_back(cs);
        end
      end
      default: ;
    endcase
  endfunction

  // Operand values lean toward the extremes now and then
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_cmd(wsma_action_e a, int r, int c, logic signed [15:0] v);
    cmd_t cmd;
    cmd.action = a;
    cmd.row    = 4'(r);
    cmd.col    = 4'(c);
    cmd.value  = v;
    cmd_q.push_back(cmd);
  endtask

  // Driver: one word per handshake, valid held until taken; gap-free for a stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid     <= 1'b0;
      s_data      <= '0;
      cmds_taken  <= 0;
      steps_taken <= 0;
    end else begin
      if (s_valid && s_axis_tready) begin
        update_array_model(cur_cmd);
        cmds_taken <= cmds_taken + 1;
        if (cur_cmd.action == ACT_STEP) steps_taken <= steps_taken + 1;
      end
      if (!s_valid || s_axis_tready) begin
        if (cmd_q.size() != 0 &&
            ((cmds_taken >= 150 && cmds_taken < 260) || $urandom_range(99) >= 38)) begin
          cur_cmd = cmd_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= S_TDATA_W'({cur_cmd.value, cur_cmd.col, cur_cmd.row, cur_cmd.action});
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Sink ready: random stalls, one long hold-off, and a stall-free window
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sums_seen >= 48) begin
      m_ready   <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      m_ready <= (sums_seen >= 200 && sums_seen < 450) || $urandom_range(99) >= 38;
    end
  end

  // Monitor: compare each taken word with the oldest predicted column sum
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_seen <= 0;
    end else if (m_axis_tvalid && m_ready) begin
      sums_seen <= sums_seen + 1;
      got_col  = m_axis_tdata[3:0];
      got_psum = $signed(m_axis_tdata[43:4]);
      if (col_sums_q.size() == 0) begin
        $display("%0t: unexpected word col=%0d psum=%0d last=%0b",
                 $time, got_col, got_psum, m_axis_tlast);
        errors++;
      end else begin
        want = col_sums_q.pop_front();
        if (got_col !== want.column) begin
          $display("%0t: column mismatch exp=%0d got=%0d", $time, want.column, got_col);
          errors++;
        end
        if (got_psum !== want.psum) begin
          $display("%0t: psum mismatch col=%0d exp=%0d got=%0d",
                   $time, want.column, want.psum, got_psum);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: tlast mismatch col=%0d exp=%0b got=%0b",
                   $time, want.column, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= DOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, DOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int kind;
    int n;
    int j;
    logic signed [15:0] e1;
    logic signed [15:0] e2;

    for (int r = 0; r < ROWS; r++) begin
      staged_acts[r] = '0;
      for (int k = 0; k < COLS; k++) begin
        weight_mem[r][k] = '0;
        act_mem[r][k]    = '0;
      end
    end

    // Directed: corner weights, extreme activations, restaging a row, shifting, clear
    push_cmd(ACT_LOAD_W, 0, 0, 16'sh8000);
    push_cmd(ACT_LOAD_W, 15, 15, 16'sh7fff);
    push_cmd(ACT_LOAD_W, 0, 15, 16'sh7fff);
    push_cmd(ACT_LOAD_W, 15, 0, 16'sh8000);
    push_cmd(ACT_STAGE, 0, 0, 16'sh8000);
    push_cmd(ACT_STAGE, 15, 0, 16'sh8000);
    push_cmd(ACT_STAGE, 15, 0, 16'sh7fff);   // overwrites the previous stage
    push_cmd(ACT_STEP, 0, 0, 16'sh0000);
    push_cmd(ACT_STEP, 15, 15, 16'shffff);   // staged buffer is empty now
    push_cmd(ACT_LOAD_W, 5, 1, -16'sd1);
    push_cmd(ACT_STAGE, 5, 0, 16'sd1);
    push_cmd(ACT_STEP, 0, 0, 16'sh0000);
    push_cmd(ACT_CLEAR_W, 0, 0, 16'sh0000);
    push_cmd(ACT_STEP, 0, 0, 16'sh0000);     // all sums zero after clear
    push_cmd(ACT_LOAD_W, 7, 9, 16'sh5a5a);
    push_cmd(ACT_LOAD_W, 8, 6, 16'sha5a5);
    push_cmd(ACT_LOAD_W, 10, 0, 16'sh0100);  // weight of 1.0
    push_cmd(ACT_STAGE, 10, 0, -16'sd1);
    push_cmd(ACT_STAGE, 8, 0, 16'sh7fff);
    push_cmd(ACT_STEP, 0, 0, 16'sh0000);
    push_cmd(ACT_STEP, 0, 0, 16'sh0000);

    // Random: mostly load/stage/step waves, plus full-column extremes, clears and noise
    while (cmd_q.size() < N_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        n = $urandom_range(6);
        repeat (n) push_cmd(ACT_LOAD_W, $urandom_range(15), $urandom_range(15), pick_value());
        n = $urandom_range(16, 1);
        repeat (n) push_cmd(ACT_STAGE, $urandom_range(15), $urandom_range(15), pick_value());
        push_cmd(ACT_STEP, $urandom_range(15), $urandom_range(15), pick_value());
      end else if (kind < 65) begin
        j  = $urandom_range(15);
        e1 = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
        e2 = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
        for (int r = 0; r < ROWS; r++) push_cmd(ACT_LOAD_W, r, j, e1);
        for (int r = 0; r < ROWS; r++) push_cmd(ACT_STAGE, r, 0, e2);
        push_cmd(ACT_STEP, 0, 0, 16'sh0000);
      end else if (kind < 72) begin
        push_cmd(ACT_CLEAR_W, $urandom_range(15), $urandom_range(15), pick_value());
        push_cmd(ACT_STEP, 0, 0, 16'sh0000);
      end else if (kind < 88) begin
        n = $urandom_range(4, 1);
        repeat (n) begin
          case ($urandom_range(3))
            0: push_cmd(ACT_LOAD_W, $urandom_range(15), $urandom_range(15), pick_value());
            1: push_cmd(ACT_STAGE, $urandom_range(15), $urandom_range(15), pick_value());
            2: push_cmd(ACT_STEP, $urandom_range(15), $urandom_range(15), pick_value());
            default: push_cmd(ACT_CLEAR_W, $urandom_range(15), $urandom_range(15),
                              pick_value());
          endcase
        end
      end else begin
        n = $urandom_range(3, 1);
        repeat (n) push_cmd(ACT_STEP, 0, 0, 16'sh0000);
      end
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all commands taken and every column sum seen
    while (cmd_q.size() != 0 || s_valid || col_sums_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Sent %0d commands including %0d steps; checked %0d column sums.",
             cmds_taken, steps_taken, sums_seen);
    $display("Run covered a long sink hold-off and gap-free stretches on both streams.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/wsma_pkg.sv
rtl/wsma_cell.sv
rtl/weight_stationary_mac_array_core.sv
rtl/wsma_checker.sv
tb/tb.sv
